@@ hdl/fbcs_pkg.sv @@
package fbcs_pkg;

  localparam int SCREEN_SIZE = 248;
  localparam int DEPTH       = SCREEN_SIZE * SCREEN_SIZE;
  localparam int AW          = $clog2(DEPTH);

  localparam logic [7:0]    LAST_COL   = 8'(SCREEN_SIZE - 1);
  localparam logic [AW-1:0] LAST_ADDR  = AW'(DEPTH - 1);
  localparam logic [23:0]   RESET_FILL = 24'h00FFFF;

  // Input item modes
  localparam logic [1:0] MODE_RGB    = 2'd0;
  localparam logic [1:0] MODE_PACKED = 2'd1;
  localparam logic [1:0] MODE_SCAN   = 2'd2;
  localparam logic [1:0] MODE_CLEAR  = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CRT_MODE = 1'b0;
  localparam logic CFG_SCALE    = 1'b1;

  // Start request from the sequencer to the scan-out unit
  typedef struct packed {
    logic       start;
    logic       crt;
    logic [2:0] scale;
  } scan_ctl_t;

  function automatic logic [23:0] dim_px(input logic [23:0] v);
    return {1'b0, v[23:17], 1'b0, v[15:9], 1'b0, v[7:1]};
  endfunction

  // Per channel (a + c) >> 1, or >> 2 when quarter is set
  function automatic logic [23:0] avg_px(input logic [23:0] a, input logic [23:0] c,
                                         input logic quarter);
    logic [8:0]  sum;
    logic [23:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      sum = {1'b0, a[i*8 +: 8]} + {1'b0, c[i*8 +: 8]};
      r[i*8 +: 8] = quarter ? {1'b0, sum[8:2]} : sum[8:1];
    end
    return r;
  endfunction

  // Per channel (a + 2c) / 3, divide by reciprocal 683/2048 (exact below 768)
  function automatic logic [23:0] blend3_px(input logic [23:0] a, input logic [23:0] c);
    logic [9:0]  sum;
    logic [19:0] prod;
    logic [23:0] r;
    r = '0;
    for (int i = 0; i < 3; i++) begin
      sum  = {2'b0, a[i*8 +: 8]} + {1'b0, c[i*8 +: 8], 1'b0};
      prod = {10'b0, sum} * 20'd683;
      r[i*8 +: 8] = prod[18:11];
    end
    return r;
  endfunction

  function automatic logic [23:0] crt_px(input logic [2:0] s, input logic [2:0] row,
                                         input logic [2:0] col, input logic [23:0] c,
                                         input logic [23:0] p, input logic [23:0] n);
    logic [23:0] v;
    logic        dim_row;
    v = c;
    dim_row = (s == 3'd3) ? (row == 3'd2) : (row == 3'd0 || row == 3'd3);
    if (s == 3'd1) begin
      return c;
    end
    if (s == 3'd2) begin
      if (row == 3'd0) return (col == 3'd0) ? c : avg_px(c, n, 1'b0);
      return (col == 3'd0) ? dim_px(c) : avg_px(c, n, 1'b1);
    end
    if (s == 3'd5 && row == 3'd4) begin
      return '0;
    end
    if (col == 3'd0) begin
      v = blend3_px(p, c);
    end else if (col == s - 3'd1) begin
      v = blend3_px(n, c);
    end
    return dim_row ? dim_px(v) : v;
  endfunction

endpackage

@@ hdl/fbcs_ram.sv @@
module fbcs_ram #(
  parameter int DW    = 24,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hdl/fbcs_scan.sv @@
module fbcs_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  fbcs_pkg::scan_ctl_t ctl,
  input  logic [23:0]         c_px,
  input  logic [23:0]         p_px,
  input  logic [23:0]         n_px,
  output logic                busy,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_sub_row,
  output logic [2:0]          out_sub_col,
  output logic [23:0]         out_pixel_rgb,
  output logic                out_last
);

  logic        busy_r, busy_nxt;
  logic        vld_r, vld_nxt;
  logic [2:0]  row_r, row_nxt, col_r, col_nxt;
  logic [2:0]  s_r;
  logic        crt_r;
  logic [23:0] c_r, p_r, n_r;
  logic [2:0]  orow_r, ocol_r;
  logic [23:0] opx_r;
  logic        olast_r;
  logic        load, last_now;
  logic [23:0] px;

  assign load     = busy_r && (!vld_r || !out_stall);
  assign last_now = (row_r == s_r - 3'd1) && (col_r == s_r - 3'd1);
  assign px       = crt_r ? fbcs_pkg::crt_px(s_r, row_r, col_r, c_r, p_r, n_r) : c_r;

  // Walk the block in row-major order
  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    vld_nxt  = vld_r;
    if (vld_r && !out_stall) vld_nxt = 1'b0;
    if (load) begin
      vld_nxt = 1'b1;
      if (last_now) begin
        busy_nxt = 1'b0;
      end else if (col_r == s_r - 3'd1) begin
        col_nxt = '0;
        row_nxt = row_r + 3'd1;
      end else begin
        col_nxt = col_r + 3'd1;
      end
    end
    if (ctl.start) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      col_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      vld_r  <= vld_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  // Capture operands at start, output register on load
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      s_r   <= ctl.scale;
      crt_r <= ctl.crt;
      c_r   <= c_px;
      p_r   <= p_px;
      n_r   <= n_px;
    end
    if (load) begin
      orow_r  <= row_r;
      ocol_r  <= col_r;
      opx_r   <= px;
      olast_r <= last_now;
    end
  end

  assign busy          = busy_r;
  assign out_valid     = vld_r;
  assign out_sub_row   = orow_r;
  assign out_sub_col   = ocol_r;
  assign out_pixel_rgb = opx_r;
  assign out_last      = olast_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("scan started while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (row_r < s_r) && (col_r < s_r)) else $error("scan counter out of block");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (load && last_now && !ctl.start) |=> !busy_r) else $error("scan ran past last");

endmodule

@@ hdl/framebuffer_blend_crt_scaler_core.sv @@
// Channel  | Handshake           | Payload
// in_      | in_valid/in_stall   | mode x y red green blue translucent packed_color
// out_     | out_valid/out_stall | sub_row sub_col pixel_rgb last
// cfg_     | cfg_valid/cfg_ready | index (0 crt_mode, 1 scale), data
//
// Writes go through accept, read and write back on the single frame RAM port.
// A scan fetches center, left and right pixels (RDC, RDP, RDN, GO), then one output per
// cycle while out_stall is low; scale*scale outputs. A clear writes all 61504 RAM words.
// After reset the same walk fills the store with cyan; in_stall is high meanwhile.
// Output stalls hold the scan unit; the next item is accepted once the scan unit is idle.
module framebuffer_blend_crt_scaler_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_x,
  input  logic [7:0]  in_y,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        in_translucent,
  input  logic [15:0] in_packed_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_sub_row,
  output logic [2:0]  out_sub_col,
  output logic [23:0] out_pixel_rgb,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [2:0]  cfg_data
);

  localparam int AW = fbcs_pkg::AW;

  typedef enum logic [8:0] {
    ST_CLR  = 9'b000000001,
    ST_IDLE = 9'b000000010,
    ST_WRD  = 9'b000000100,
    ST_WWB  = 9'b000001000,
    ST_RDC  = 9'b000010000,
    ST_RDP  = 9'b000100000,
    ST_RDN  = 9'b001000000,
    ST_GO   = 9'b010000000,
    ST_EMIT = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [23:0]        fill_r, fill_nxt;
  logic               crt_r;
  logic [2:0]         scale_r;
  logic [AW-1:0]      idx_r;
  logic [7:0]         x_r;
  logic [23:0]        new_r, c_r, p_r;
  logic               tr_r;
  logic               accept, in_range;
  logic [15:0]        prod;
  logic [AW-1:0]      idx_in;
  logic               we;
  logic [AW-1:0]      addr;
  logic [23:0]        wdata, rdata;
  logic [2:0]         s_norm;
  logic               scan_busy;
  fbcs_pkg::scan_ctl_t ctl;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign in_range = (32'(in_x) < fbcs_pkg::SCREEN_SIZE) && (32'(in_y) < fbcs_pkg::SCREEN_SIZE);
  assign prod     = {8'b0, in_y} * 16'(fbcs_pkg::SCREEN_SIZE);
  assign idx_in   = AW'(prod + {8'b0, in_x});
  assign cfg_ready = 1'b1;

  // Config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crt_r   <= 1'b1;
      scale_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fbcs_pkg::CFG_CRT_MODE: crt_r   <= cfg_data[0];
        fbcs_pkg::CFG_SCALE:    scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (scale_r)
      3'd0:                s_norm = 3'd1;
      3'd6, 3'd7:          s_norm = 3'd5;
      default:             s_norm = scale_r;
    endcase
  end

  // Sequence RAM accesses per transaction
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    fill_nxt  = fill_r;
    case (state_r)
      ST_CLR: begin
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == fbcs_pkg::LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_mode == fbcs_pkg::MODE_CLEAR) begin
            fill_nxt  = {in_red, in_green, in_blue};
            cnt_nxt   = '0;
            state_nxt = ST_CLR;
          end else if (in_range) begin
            state_nxt = (in_mode == fbcs_pkg::MODE_SCAN) ? ST_RDC : ST_WRD;
          end
        end
      end
      ST_WRD:  state_nxt = ST_WWB;
      ST_WWB:  state_nxt = ST_IDLE;
      ST_RDC:  state_nxt = ST_RDP;
      ST_RDP:  state_nxt = ST_RDN;
      ST_RDN:  state_nxt = ST_GO;
      ST_GO:   state_nxt = ST_EMIT;
      ST_EMIT: if (!scan_busy) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      cnt_r   <= '0;
      fill_r  <= fbcs_pkg::RESET_FILL;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fill_r  <= fill_nxt;
    end
  end

  // Hold the transaction payload and gathered pixels
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= idx_in;
      x_r   <= in_x;
      if (in_mode == fbcs_pkg::MODE_PACKED) begin
        new_r <= {in_packed_color[14:10], 3'b0, in_packed_color[9:5], 3'b0,
                  in_packed_color[4:0], 3'b0};
        tr_r  <= in_packed_color[15];
      end else begin
        new_r <= {in_red, in_green, in_blue};
        tr_r  <= in_translucent;
      end
    end
    if (state_r == ST_RDP) c_r <= rdata;
    if (state_r == ST_RDN) p_r <= (x_r == 8'd0) ? '0 : rdata;
  end

  // RAM port
  always_comb begin
    we    = 1'b0;
    addr  = idx_r;
    wdata = new_r;
    case (state_r)
      ST_CLR: begin
        we    = 1'b1;
        addr  = cnt_r;
        wdata = fill_r;
      end
      ST_WWB: begin
        we    = 1'b1;
        wdata = tr_r ? fbcs_pkg::avg_px(rdata, new_r, 1'b0) : new_r;
      end
      ST_RDP:  addr = (x_r == 8'd0) ? idx_r : idx_r - AW'(1);
      ST_RDN:  addr = (x_r == fbcs_pkg::LAST_COL) ? idx_r : idx_r + AW'(1);
      default: addr = idx_r;
    endcase
  end

  fbcs_ram #(.DW(24), .DEPTH(fbcs_pkg::DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign ctl.start = (state_r == ST_GO);
  assign ctl.crt   = crt_r;
  assign ctl.scale = s_norm;

  fbcs_scan u_scan (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .c_px          (c_r),
    .p_px          (p_r),
    .n_px          ((x_r == fbcs_pkg::LAST_COL) ? 24'd0 : rdata),
    .busy          (scan_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sub_row   (out_sub_row),
    .out_sub_col   (out_sub_col),
    .out_pixel_rgb (out_pixel_rgb),
    .out_last      (out_last)
  );

  a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT || state_r == ST_GO) |-> !we) else $error("write during scan");
  a_clr_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR && cnt_r == fbcs_pkg::LAST_ADDR) |=> state_r == ST_IDLE)
    else $error("clear walk overran");
  a_wb_follows: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WRD |=> we) else $error("write back missed");

endmodule
